// ----- rtl/edf_tick_scheduler_top_macros.svh -----
// Assertion macros shared by the scheduler RTL.
// Included by the controller and the top level; depends on nothing else.
`ifndef EDF_TICK_SCHEDULER_TOP_MACROS_SVH
`define EDF_TICK_SCHEDULER_TOP_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define EDFT_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define EDFT_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- rtl/edft_pkg.sv -----
// Types and codes shared by the scheduler modules.
// Depends on nothing; imported by the cell, the controller and the top level.
`timescale 1ns / 1ps
`default_nettype none

package edft_pkg;

   // Request operation codes.
   localparam logic OP_TICK = 1'b0;
   localparam logic OP_LOAD = 1'b1;

   // Controller states.
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_COMMIT
   } edft_state_type;

   // Flags travelling along the selection chain with the running best.
   typedef struct packed {
      logic valid;
      logic found;
   } edft_scan_type;

   // Controller strobes towards the datapath.
   typedef struct packed {
      logic accept;
      logic launch;
      logic load;
      logic tick;
   } edft_ctl_type;

   // Per-cell commit command.
   typedef struct packed {
      logic load;
      logic tick;
      logic picked;
   } edft_cmd_type;

endpackage

`default_nettype wire

// ----- rtl/edft_cell.sv -----
// One task cell: holds a task's table entry and running counters, takes part in
// the selection chain and applies the tick update. Depends on edft_pkg.
`timescale 1ns / 1ps
`default_nettype none

module edft_cell
   import edft_pkg::*;
#(
   parameter int TIME_BITS  = 16,
   parameter int IDX_BITS   = 3,
   parameter int CELL_INDEX = 0
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 active,
   input  edft_scan_type        scan_in,
   input  logic [TIME_BITS-1:0] best_in,
   input  logic [IDX_BITS-1:0]  pick_in,
   output edft_scan_type        scan_out,
   output logic [TIME_BITS-1:0] best_out,
   output logic [IDX_BITS-1:0]  pick_out,
   input  edft_cmd_type         cmd,
   input  logic [TIME_BITS-1:0] load_period,
   input  logic [TIME_BITS-1:0] load_wcet,
   input  logic [TIME_BITS-1:0] load_deadline,
   output logic                 miss
);

   logic [TIME_BITS-1:0] period_ff, period_in;
   logic [TIME_BITS-1:0] budget_ff, budget_in;
   logic [TIME_BITS-1:0] deadline_ff, deadline_in;
   logic [TIME_BITS-1:0] dleft_ff, dleft_in;
   logic [TIME_BITS-1:0] bleft_ff, bleft_in;
   logic [TIME_BITS-1:0] phase_ff, phase_in;
   edft_scan_type        scan_ff, scan_nxt_in;
   logic [TIME_BITS-1:0] best_ff, best_in_nxt;
   logic [IDX_BITS-1:0]  pick_ff, pick_in_nxt;
   logic [TIME_BITS-1:0] bleft_dec;
   logic                 period_end;
   logic                 candidate;

   // Selection step: this task beats the running best if it is active, has
   // budget left and a strictly smaller deadline left, or if none was found yet.
   always_comb begin
      candidate = scan_in.valid && active && (bleft_ff != '0) &&
                  (!scan_in.found || (dleft_ff < best_in));
      scan_nxt_in.valid = scan_in.valid;
      scan_nxt_in.found = scan_in.found || candidate;
      best_in_nxt       = candidate ? dleft_ff : best_in;
      pick_in_nxt       = candidate ? IDX_BITS'(CELL_INDEX) : pick_in;
   end

   // Table load and tick update.
   always_comb begin
      period_in   = period_ff;
      budget_in   = budget_ff;
      deadline_in = deadline_ff;
      dleft_in    = dleft_ff;
      bleft_in    = bleft_ff;
      phase_in    = phase_ff;
      miss        = 1'b0;
      bleft_dec   = cmd.picked ? (bleft_ff - TIME_BITS'(1)) : bleft_ff;
      period_end  = (phase_ff == (period_ff - TIME_BITS'(1)));
      if (cmd.load) begin
         period_in   = load_period;
         budget_in   = load_wcet;
         deadline_in = load_deadline;
         dleft_in    = load_deadline;
         bleft_in    = load_wcet;
         phase_in    = '0;
      end else if (cmd.tick && active) begin
         if (period_end) begin
            dleft_in = deadline_ff;
            bleft_in = budget_ff;
            phase_in = '0;
         end else begin
            if (dleft_ff != '0) begin
               dleft_in = dleft_ff - TIME_BITS'(1);
            end else if (bleft_dec != '0) begin
               miss = 1'b1;
            end
            bleft_in = bleft_dec;
            phase_in = phase_ff + TIME_BITS'(1);
         end
      end
   end

   // Task state registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         period_ff   <= '0;
         budget_ff   <= '0;
         deadline_ff <= '0;
         dleft_ff    <= '0;
         bleft_ff    <= '0;
         phase_ff    <= '0;
      end else begin
         period_ff   <= period_in;
         budget_ff   <= budget_in;
         deadline_ff <= deadline_in;
         dleft_ff    <= dleft_in;
         bleft_ff    <= bleft_in;
         phase_ff    <= phase_in;
      end
   end

   // Chain stage towards the next cell.
   always_ff @(posedge clock) begin
      if (reset) begin
         scan_ff <= '0;
      end else begin
         scan_ff <= scan_nxt_in;
      end
      best_ff <= best_in_nxt;
      pick_ff <= pick_in_nxt;
   end

   assign scan_out = scan_ff;
   assign best_out = best_ff;
   assign pick_out = pick_ff;

endmodule

`default_nettype wire

// ----- rtl/edft_ctrl.sv -----
// Sequencer for the scheduler: request handshake, selection pass, commit and
// the response valid flag. Depends on edft_pkg and the assertion macros.
`timescale 1ns / 1ps
`default_nettype none
`include "edf_tick_scheduler_top_macros.svh"

module edft_ctrl
   import edft_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   input  logic         req_opcode,
   output logic         req_stall,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   input  logic         scan_done,
   output edft_ctl_type ctl
);

   edft_state_type state_ff, state_in;
   logic           op_ff, op_in;
   logic           rsp_valid_ff, rsp_valid_in;
   logic           out_free;

   // Next state and strobes.
   always_comb begin
      state_in     = state_ff;
      op_in        = op_ff;
      ctl          = '0;
      out_free     = !rsp_valid_ff || !rsp_stall;
      req_stall    = (state_ff != ST_IDLE);
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               ctl.accept = 1'b1;
               op_in      = req_opcode;
               if (req_opcode == OP_TICK) begin
                  ctl.launch = 1'b1;
                  state_in   = ST_SCAN;
               end else begin
                  state_in   = ST_COMMIT;
               end
            end
         end
         ST_SCAN: begin
            if (scan_done) begin
               state_in = ST_COMMIT;
            end
         end
         ST_COMMIT: begin
            if (out_free) begin
               ctl.load     = (op_ff == OP_LOAD);
               ctl.tick     = (op_ff == OP_TICK);
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      op_ff <= op_in;
   end

   assign rsp_valid = rsp_valid_ff;

   // The selection result only arrives during a selection pass.
   `EDFT_ASSERT_NOW(a_done_in_scan, clock, reset, scan_done, state_ff == ST_SCAN, "scan result outside selection pass")
   // A launched tick always enters the selection pass.
   `EDFT_ASSERT_NEXT(a_launch_scan, clock, reset, ctl.launch, state_ff == ST_SCAN, "tick did not start a selection pass")
   // Every commit presents a response in the following cycle.
   `EDFT_ASSERT_NEXT(a_commit_rsp, clock, reset, ctl.load || ctl.tick, rsp_valid_ff, "commit without response")

endmodule

`default_nettype wire

// ----- rtl/edf_tick_scheduler_top.sv -----
// Earliest-deadline-first tick scheduler, top level.
// Request channel (req_*): valid/stall; opcode selects a tick or a table load.
// Response channel (rsp_*): valid/stall; one response per request, in order.
// Configuration (csr_*): csr_wr_en writes csr_wr_data into the task count,
// which must only change while no request is in flight.
// A load request writes one task entry and restarts its counters; it is
// answered after its commit with all response fields zero.
// A tick request passes a selection wave along the row of MAX_TASKS task
// cells, one cell per cycle, then updates every active cell at commit; the
// response register is written at that commit, and the next request is
// accepted only once the sequencer is back in idle after the commit.
// The length of the cell chain sets the duration of a selection pass.
// Requests are held off (req_stall high) whilst one is being processed.
// If the receiver stalls, the response register holds its value and the
// commit of the next request waits until the register is free.
// Synchronous reset clears the task table, the task count, the sequencer state and the response valid flag.
// Depends on edft_pkg, edft_cell, edft_ctrl and the assertion macros.
`timescale 1ns / 1ps
`default_nettype none
`include "edf_tick_scheduler_top_macros.svh"

module edf_tick_scheduler_top
   import edft_pkg::*;
#(
   parameter int MAX_TASKS = 8,
   parameter int TIME_BITS = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_opcode,
   input  logic [2:0]  req_task_index,
   input  logic [15:0] req_period,
   input  logic [15:0] req_wcet,
   input  logic [15:0] req_deadline,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_scheduled_valid,
   output logic [2:0]  rsp_scheduled_task,
   output logic [7:0]  rsp_miss_mask,
   input  logic        csr_wr_en,
   input  logic [3:0]  csr_wr_data
);

   localparam int IDX_BITS = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
   localparam int PICK_W   = (IDX_BITS > 3) ? IDX_BITS : 3;

   edft_ctl_type         ctl;
   logic [3:0]           task_count_ff, task_count_in;
   logic [2:0]           idx_ff;
   logic [15:0]          period_ff, wcet_ff, deadline_ff;
   logic                 found_ff;
   logic [IDX_BITS-1:0]  pick_ff;
   logic                 sched_valid_ff, sched_valid_in;
   logic [2:0]           sched_task_ff, sched_task_in;
   logic [7:0]           miss_mask_ff, miss_mask_in;
   logic [PICK_W-1:0]    pick_wide;
   logic [7:0]           miss_vec;
   logic [MAX_TASKS-1:0] cell_miss;
   logic [MAX_TASKS-1:0] cell_picked;
   logic [TIME_BITS-1:0] ld_period, ld_wcet, ld_deadline;
   logic                 scan_done;

   edft_scan_type        chain_flag [0:MAX_TASKS];
   logic [TIME_BITS-1:0] chain_best [0:MAX_TASKS];
   logic [IDX_BITS-1:0]  chain_pick [0:MAX_TASKS];
   edft_cmd_type         cell_cmd   [0:MAX_TASKS-1];

   // Sequencer.
   edft_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_opcode (req_opcode),
      .req_stall  (req_stall),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .scan_done  (scan_done),
      .ctl        (ctl)
   );

   // Task count register.
   always_comb begin
      task_count_in = csr_wr_en ? csr_wr_data : task_count_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         task_count_ff <= '0;
      end else begin
         task_count_ff <= task_count_in;
      end
   end

   // Request capture at acceptance.
   always_ff @(posedge clock) begin
      if (ctl.accept) begin
         idx_ff      <= req_task_index;
         period_ff   <= req_period;
         wcet_ff     <= req_wcet;
         deadline_ff <= req_deadline;
      end
   end

   assign ld_period   = TIME_BITS'(period_ff);
   assign ld_wcet     = TIME_BITS'(wcet_ff);
   assign ld_deadline = TIME_BITS'(deadline_ff);

   // Head of the selection chain.
   assign chain_flag[0].valid = ctl.launch;
   assign chain_flag[0].found = 1'b0;
   assign chain_best[0]       = '0;
   assign chain_pick[0]       = '0;

   // Row of task cells.
   for (genvar i = 0; i < MAX_TASKS; i++) begin : g_cell
      assign cell_picked[i]     = found_ff && (pick_ff == IDX_BITS'(i));
      assign cell_cmd[i].load   = ctl.load && (int'(idx_ff) == i);
      assign cell_cmd[i].tick   = ctl.tick;
      assign cell_cmd[i].picked = ctl.tick && cell_picked[i];

      edft_cell #(
         .TIME_BITS  (TIME_BITS),
         .IDX_BITS   (IDX_BITS),
         .CELL_INDEX (i)
      ) u_cell (
         .clock         (clock),
         .reset         (reset),
         .active        (int'(task_count_ff) > i),
         .scan_in       (chain_flag[i]),
         .best_in       (chain_best[i]),
         .pick_in       (chain_pick[i]),
         .scan_out      (chain_flag[i+1]),
         .best_out      (chain_best[i+1]),
         .pick_out      (chain_pick[i+1]),
         .cmd           (cell_cmd[i]),
         .load_period   (ld_period),
         .load_wcet     (ld_wcet),
         .load_deadline (ld_deadline),
         .miss          (cell_miss[i])
      );
   end

   assign scan_done = chain_flag[MAX_TASKS].valid;

   // Selection result, latched as the wave leaves the last cell.
   always_ff @(posedge clock) begin
      if (scan_done) begin
         found_ff <= chain_flag[MAX_TASKS].found;
         pick_ff  <= chain_pick[MAX_TASKS];
      end
   end

   // Only the first eight tasks report misses.
   for (genvar b = 0; b < 8; b++) begin : g_miss
      if (b < MAX_TASKS) begin : g_used
         assign miss_vec[b] = cell_miss[b];
      end else begin : g_unused
         assign miss_vec[b] = 1'b0;
      end
   end

   assign pick_wide = PICK_W'(pick_ff);

   // Response register, written at commit.
   always_comb begin
      sched_valid_in = sched_valid_ff;
      sched_task_in  = sched_task_ff;
      miss_mask_in   = miss_mask_ff;
      if (ctl.load) begin
         sched_valid_in = 1'b0;
         sched_task_in  = '0;
         miss_mask_in   = '0;
      end else if (ctl.tick) begin
         sched_valid_in = found_ff;
         sched_task_in  = found_ff ? pick_wide[2:0] : 3'd0;
         miss_mask_in   = miss_vec;
      end
   end

   always_ff @(posedge clock) begin
      sched_valid_ff <= sched_valid_in;
      sched_task_ff  <= sched_task_in;
      miss_mask_ff   <= miss_mask_in;
   end

   assign rsp_scheduled_valid = sched_valid_ff;
   assign rsp_scheduled_task  = sched_task_ff;
   assign rsp_miss_mask       = miss_mask_ff;

   // An idle or load response names task zero.
   `EDFT_ASSERT_NOW(a_idle_task_zero, clock, reset, rsp_valid && !rsp_scheduled_valid, rsp_scheduled_task == 3'd0, "idle response with nonzero task")
   // At most one cell takes budget on a tick.
   `EDFT_ASSERT_NOW(a_one_picked, clock, reset, ctl.tick, $onehot0(cell_picked), "more than one task picked")
   // A stalled response stays valid and unchanged.
   `EDFT_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_miss_mask) && $stable(rsp_scheduled_task), "stalled response changed")

endmodule

`default_nettype wire

// ----- tb/edf_tick_scheduler_checker.sv -----
// Checker for the EDF tick scheduler: it watches the request, response and
// register ports, predicts each response and compares it field by field.
// Depends on edft_pkg for the operation codes.
`timescale 1ns / 1ps

module edf_tick_scheduler_checker
   import edft_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_stall,
   input  logic        req_opcode,
   input  logic [2:0]  req_task_index,
   input  logic [15:0] req_period,
   input  logic [15:0] req_wcet,
   input  logic [15:0] req_deadline,
   input  logic        rsp_valid,
   input  logic        rsp_stall,
   input  logic        rsp_scheduled_valid,
   input  logic [2:0]  rsp_scheduled_task,
   input  logic [7:0]  rsp_miss_mask,
   input  logic        csr_wr_en,
   input  logic [3:0]  csr_wr_data,
   output int          outstanding,
   output int          failures,
   output int          loads_seen,
   output int          ticks_seen,
   output int          runs_seen,
   output int          misses_seen
);

   localparam int TASK_SLOTS = 8;

   typedef struct packed {
      logic       run_valid;
      logic [2:0] run_index;
      logic [7:0] miss_mask;
   } sched_result_t;

   // Own copy of the task count and of the task table with its counters.
   logic [3:0]  task_limit;
   logic [15:0] period_tab [TASK_SLOTS];
   logic [15:0] budget_tab [TASK_SLOTS];
   logic [15:0] deadline_tab [TASK_SLOTS];
   logic [15:0] deadline_left [TASK_SLOTS];
   logic [15:0] budget_left [TASK_SLOTS];
   logic [15:0] phase_pos [TASK_SLOTS];

   sched_result_t due_results [$];
   int fail_total = 0;
   int load_total = 0;
   int tick_total = 0;
   int run_total = 0;
   int miss_total = 0;

   task automatic report_failure(input string msg);
      $display("%0t ns: %s", $time, msg);
      fail_total++;
   endtask

   // Applies one request to the table copy and returns the response it causes.
   function automatic sched_result_t schedule_request(input logic op, input logic [2:0] idx,
         input logic [15:0] per, input logic [15:0] bud, input logic [15:0] dl);
      sched_result_t res;
      int n;
      logic [15:0] best;
      logic [15:0] period_end;
      res = '0;
      best = '0;
      if (op == OP_LOAD) begin
         period_tab[idx] = per;
         budget_tab[idx] = bud;
         deadline_tab[idx] = dl;
         deadline_left[idx] = dl;
         budget_left[idx] = bud;
         phase_pos[idx] = '0;
         return res;
      end
      n = (task_limit > TASK_SLOTS) ? TASK_SLOTS : int'(task_limit);
      // Earliest deadline among tasks with budget left; ties go to the lowest index.
      for (int j = 0; j < n; j++) begin
         if (budget_left[j] != 0 && (!res.run_valid || deadline_left[j] < best)) begin
            res.run_valid = 1'b1;
            best = deadline_left[j];
            res.run_index = 3'(j);
         end
      end
      if (res.run_valid)
         budget_left[res.run_index] = budget_left[res.run_index] - 16'd1;
      // Every active task then advances its phase within the period.
      for (int j = 0; j < n; j++) begin
         period_end = period_tab[j] - 16'd1;
         if (phase_pos[j] == period_end) begin
            deadline_left[j] = deadline_tab[j];
            budget_left[j] = budget_tab[j];
            phase_pos[j] = '0;
         end else begin
            if (deadline_left[j] != 0)
               deadline_left[j] = deadline_left[j] - 16'd1;
            else if (budget_left[j] != 0)
               res.miss_mask[j] = 1'b1;
            phase_pos[j] = phase_pos[j] + 16'd1;
         end
      end
      return res;
   endfunction

   always @(posedge clock) begin : watch_channels
      sched_result_t want;
      if (reset) begin
         task_limit = '0;
         for (int j = 0; j < TASK_SLOTS; j++) begin
            period_tab[j] = '0;
            budget_tab[j] = '0;
            deadline_tab[j] = '0;
            deadline_left[j] = '0;
            budget_left[j] = '0;
            phase_pos[j] = '0;
         end
         due_results.delete();
      end else begin
         // A response leaving this edge belongs to an earlier request.
         if (rsp_valid && !rsp_stall) begin
            if (due_results.size() == 0) begin
               report_failure("response arrived with no request waiting for one");
            end else begin
               want = due_results.pop_front();
               if (rsp_scheduled_valid !== want.run_valid)
                  report_failure($sformatf("scheduled_valid: expected %0d, got %0d",
                     want.run_valid, rsp_scheduled_valid));
               if (rsp_scheduled_task !== want.run_index)
                  report_failure($sformatf("scheduled_task: expected %0d, got %0d",
                     want.run_index, rsp_scheduled_task));
               if (rsp_miss_mask !== want.miss_mask)
                  report_failure($sformatf("miss_mask: expected %02h, got %02h",
                     want.miss_mask, rsp_miss_mask));
            end
         end
         if (req_valid && !req_stall) begin
            want = schedule_request(req_opcode, req_task_index, req_period, req_wcet,
               req_deadline);
            due_results.push_back(want);
            if (req_opcode == OP_LOAD) begin
               load_total++;
            end else begin
               tick_total++;
               if (want.run_valid)
                  run_total++;
               if (want.miss_mask != 0)
                  miss_total++;
            end
         end
         if (csr_wr_en)
            task_limit = csr_wr_data;
      end
      outstanding <= due_results.size();
      failures <= fail_total;
      loads_seen <= load_total;
      ticks_seen <= tick_total;
      runs_seen <= run_total;
      misses_seen <= miss_total;
   end

endmodule

// ----- tb/edf_tick_scheduler_top_test.sv -----
// Testbench top for the EDF tick scheduler: clock, reset, request stimulus,
// response stalls, task-count writes and the verdict.
// Depends on edft_pkg, edf_tick_scheduler_top and edf_tick_scheduler_checker.
`timescale 1ns / 1ps

module edf_tick_scheduler_top_test;
   import edft_pkg::*;

   localparam int WATCHDOG_LIMIT = 2000;
   localparam int SETTLE_CYCLES = 12;
   localparam int PHASES = 10;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   logic        req_opcode;
   logic [2:0]  req_task_index;
   logic [15:0] req_period;
   logic [15:0] req_wcet;
   logic [15:0] req_deadline;
   logic        rsp_valid;
   logic        rsp_stall;
   logic        rsp_scheduled_valid;
   logic [2:0]  rsp_scheduled_task;
   logic [7:0]  rsp_miss_mask;
   logic        csr_wr_en;
   logic [3:0]  csr_wr_data;

   int outstanding;
   int failures;
   int loads_seen;
   int ticks_seen;
   int runs_seen;
   int misses_seen;

   bit no_gaps = 1'b0;
   int rsp_hold;
   int idle_cycles;
   int settings_used = 0;

   // Task counts used by the random phases, both ends of the range included.
   logic [3:0] phase_counts [PHASES] = '{4'd8, 4'd3, 4'd15, 4'd1, 4'd0,
                                         4'd5, 4'd8, 4'd2, 4'd9, 4'd6};

   edf_tick_scheduler_top dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_opcode          (req_opcode),
      .req_task_index      (req_task_index),
      .req_period          (req_period),
      .req_wcet            (req_wcet),
      .req_deadline        (req_deadline),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_scheduled_valid (rsp_scheduled_valid),
      .rsp_scheduled_task  (rsp_scheduled_task),
      .rsp_miss_mask       (rsp_miss_mask),
      .csr_wr_en           (csr_wr_en),
      .csr_wr_data         (csr_wr_data)
   );

   edf_tick_scheduler_checker sched_watch (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_opcode          (req_opcode),
      .req_task_index      (req_task_index),
      .req_period          (req_period),
      .req_wcet            (req_wcet),
      .req_deadline        (req_deadline),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_scheduled_valid (rsp_scheduled_valid),
      .rsp_scheduled_task  (rsp_scheduled_task),
      .rsp_miss_mask       (rsp_miss_mask),
      .csr_wr_en           (csr_wr_en),
      .csr_wr_data         (csr_wr_data),
      .outstanding         (outstanding),
      .failures            (failures),
      .loads_seen          (loads_seen),
      .ticks_seen          (ticks_seen),
      .runs_seen           (runs_seen),
      .misses_seen         (misses_seen)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // Gap drawn before each request and each response; none in burst phases.
   function automatic int pick_gap();
      if (no_gaps || $urandom_range(0, 3) == 0)
         return 0;
      return $urandom_range(0, 11);
   endfunction

   // The receiver stalls a random number of cycles after each response.
   always @(posedge clock) begin
      if (reset) begin
         rsp_hold = 0;
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall)
            rsp_hold = pick_gap();
         if (rsp_hold > 0) begin
            rsp_stall <= 1'b1;
            rsp_hold--;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   // The run is abandoned if nothing moves on any port for too long.
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) || csr_wr_en) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("Watchdog expired with %0d responses still due.", outstanding);
         $display("edf_tick_scheduler_top_test NOT OK");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // Presents one request after a random gap and returns once it is accepted.
   task automatic send_request(input logic op, input logic [2:0] idx,
         input logic [15:0] per, input logic [15:0] bud, input logic [15:0] dl);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_opcode <= op;
      req_task_index <= idx;
      req_period <= per;
      req_wcet <= bud;
      req_deadline <= dl;
      do @(posedge clock); while (req_stall);
   endtask

   // A tick carries random, ignored values in the load fields.
   task automatic send_tick();
      send_request(OP_TICK, 3'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
   endtask

   // Mostly short periods so that reloads and misses happen often.
   task automatic load_random_task(input logic [2:0] idx);
      logic [15:0] per;
      logic [15:0] bud;
      logic [15:0] dl;
      if ($urandom_range(0, 5) == 0) begin
         per = 16'($urandom);
         bud = 16'($urandom);
         dl = 16'($urandom);
      end else begin
         per = 16'($urandom_range(1, 12));
         bud = 16'($urandom_range(0, per));
         dl = 16'($urandom_range(0, per));
      end
      send_request(OP_LOAD, idx, per, bud, dl);
   endtask

   // Waits until every response is back and the block is quiet, then writes the count.
   task automatic set_task_count(input logic [3:0] count);
      req_valid <= 1'b0;
      do @(posedge clock); while (outstanding != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_wr_data <= count;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      settings_used++;
   endtask

   initial begin
      int tick_run;
      reset = 1'b1;
      req_valid = 1'b0;
      req_opcode = OP_TICK;
      req_task_index = '0;
      req_period = '0;
      req_wcet = '0;
      req_deadline = '0;
      csr_wr_en = 1'b0;
      csr_wr_data = '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // No active tasks: ticks are idle whatever the table holds.
      set_task_count(4'd0);
      send_tick();
      send_request(OP_LOAD, 3'd7, 16'hFFFF, 16'hFFFF, 16'hFFFF);
      send_request(OP_LOAD, 3'd0, 16'd1, 16'd0, 16'd0);
      send_tick();

      // Count above the table size acts as a full table. Task one has a zero
      // period and a zero deadline, so it misses at once; tasks two and three tie.
      set_task_count(4'd15);
      send_request(OP_LOAD, 3'd1, 16'd0, 16'd3, 16'd0);
      send_request(OP_LOAD, 3'd2, 16'd4, 16'd2, 16'd2);
      send_request(OP_LOAD, 3'd3, 16'd4, 16'd2, 16'd2);
      send_request(OP_LOAD, 3'd0, 16'd1, 16'd1, 16'd0);
      repeat (6) send_tick();
      set_task_count(4'd8);
      repeat (3) send_tick();

      // Random phases: a full table load, then a run of ticks with the odd reload.
      for (int phase = 0; phase < PHASES; phase++) begin
         set_task_count(phase_counts[phase]);
         no_gaps = (phase % 3 == 1);
         for (int i = 0; i < 8; i++)
            load_random_task(3'(i));
         tick_run = $urandom_range(28, 42);
         for (int k = 0; k < tick_run; k++) begin
            if ($urandom_range(0, 9) == 0)
               load_random_task(3'($urandom));
            else
               send_tick();
         end
      end
      no_gaps = 1'b0;

      // Drain, then give any stray response time to show up.
      req_valid <= 1'b0;
      do @(posedge clock); while (outstanding != 0);
      repeat (2 * SETTLE_CYCLES) @(posedge clock);
      $display("Run covered %0d loads and %0d ticks under %0d task-count settings;",
         loads_seen, ticks_seen, settings_used);
      $display("%0d ticks ran a task and %0d of them flagged a deadline miss.",
         runs_seen, misses_seen);
      if (failures == 0 && outstanding == 0)
         $display("edf_tick_scheduler_top_test OK");
      else
         $display("edf_tick_scheduler_top_test NOT OK");
      $finish;
   end

endmodule
